// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked by aclk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/msposd_pkg.sv =====
// ----------------------------------------------------------------------------
// MSP OSD parser package
// Types, byte codes and defaults shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package msposd_pkg;

    localparam int SCREEN_CELLS_DEF = 1536;
    localparam int MAX_COLUMNS      = 64;
    localparam int MAX_ROWS         = 24;
    localparam int PAYLOAD_DEPTH    = 256;
    localparam int PAY_AW           = $clog2(PAYLOAD_DEPTH);

    localparam logic [7:0] CH_DOLLAR       = 8'h24;
    localparam logic [7:0] CH_M            = 8'h4D;
    localparam logic [7:0] CH_LT           = 8'h3C;
    localparam logic [7:0] CH_GT           = 8'h3E;
    localparam logic [7:0] CMD_DISPLAYPORT = 8'd182;
    localparam logic [7:0] SUB_CLEAR       = 8'd2;
    localparam logic [7:0] SUB_STRING      = 8'd3;
    localparam logic [7:0] SUB_DRAW        = 8'd4;
    localparam logic [7:0] STR_MIN_LEN     = 8'd5;
    localparam logic [8:0] STR_FIRST_CHAR  = 9'd4;

    localparam logic [6:0] COLUMNS_RST = 7'd30;
    localparam logic [4:0] ROWS_RST    = 5'd16;
    localparam logic       FC_TYPE_RST = 1'b1;

    typedef enum logic [1:0] {
        CFG_COLUMNS = 2'd0,
        CFG_ROWS    = 2'd1,
        CFG_FC_TYPE = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        P_IDLE, P_HDR, P_DIR, P_SIZE, P_CMD, P_DATA, P_CSUM
    } parse_state_t;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_EXEC, S_READ, S_CLEAR, S_COPY, S_COPY_TAIL,
        S_STR_BASE, S_STR_RD, S_STR_WR, S_RESULT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        ACT_NONE, ACT_READ, ACT_CLEAR, ACT_COPY, ACT_STRING
    } action_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic init_sweep;
        logic clear_sweep;
        logic copy_sweep;
        logic read_cap;
        logic str_setup;
        logic str_read;
        logic str_write;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        action_t act;
        logic    sweep_last;
        logic    str_end;
        logic    out_free;
        logic    in_valid;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/msposd_ctrl.sv =====
// ----------------------------------------------------------------------------
// MSP OSD parser controller
// Sequences item intake, frame actions, screen sweeps and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module msposd_ctrl
    import msposd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd,
    output logic            s_tready
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:      if (status.sweep_last) state_next = S_IDLE;
            S_IDLE:      if (status.in_valid) state_next = S_EXEC;
            S_EXEC: begin
                case (status.act)
                    ACT_READ:   state_next = S_READ;
                    ACT_CLEAR:  state_next = S_CLEAR;
                    ACT_COPY:   state_next = S_COPY;
                    ACT_STRING: state_next = S_STR_BASE;
                    default:    state_next = S_RESULT;
                endcase
            end
            S_READ:      state_next = S_RESULT;
            S_CLEAR:     if (status.sweep_last) state_next = S_RESULT;
            S_COPY:      if (status.sweep_last) state_next = S_COPY_TAIL;
            S_COPY_TAIL: state_next = S_RESULT;
            S_STR_BASE:  state_next = S_STR_RD;
            S_STR_RD:    state_next = S_STR_WR;
            S_STR_WR:    state_next = status.str_end ? S_RESULT : S_STR_RD;
            S_RESULT:    if (status.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd             = '0;
        s_tready        = (state_reg == S_IDLE);
        cmd.accept      = (state_reg == S_IDLE) && status.in_valid;
        cmd.exec        = (state_reg == S_EXEC);
        cmd.init_sweep  = (state_reg == S_INIT);
        cmd.clear_sweep = (state_reg == S_CLEAR);
        cmd.copy_sweep  = (state_reg == S_COPY);
        cmd.read_cap    = (state_reg == S_READ);
        cmd.str_setup   = (state_reg == S_STR_BASE);
        cmd.str_read    = (state_reg == S_STR_RD);
        cmd.str_write   = (state_reg == S_STR_WR);
        cmd.emit        = (state_reg == S_RESULT) && status.out_free;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/msposd_dp.sv =====
// ----------------------------------------------------------------------------
// MSP OSD parser datapath
// Frame parser registers, payload store, both screen memories and output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module msposd_dp
    import msposd_pkg::*;
#(
    parameter int SCREEN_CELLS = SCREEN_CELLS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire ctrl_cmd_t   cmd,
    output dp_status_t       status,
    input  wire logic        s_tvalid,
    input  wire logic [23:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    output logic [1:0]       m_tuser,
    input  wire logic        cfg_valid,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data
);

    localparam int AW = $clog2(SCREEN_CELLS);

    // Configuration.
    logic [6:0] cols_reg;
    logic [4:0] rows_reg;
    logic       fc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= COLUMNS_RST;
            rows_reg <= ROWS_RST;
            fc_reg   <= FC_TYPE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_COLUMNS: cols_reg <= cfg_data;
                CFG_ROWS:    rows_reg <= cfg_data[4:0];
                CFG_FC_TYPE: fc_reg   <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Latched input item.
    logic        in_op_reg;
    logic [7:0]  in_byte_reg;
    logic [10:0] in_idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_op_reg   <= s_tuser[0];
            in_byte_reg <= s_tdata[7:0];
            in_idx_reg  <= s_tdata[18:8];
        end
    end

    // Parser state.
    parse_state_t pst_reg;
    logic         dir_reg;
    logic [7:0]   size_reg;
    logic [7:0]   count_reg;
    logic [7:0]   cmd_reg;
    logic [7:0]   xor_reg;
    logic         wempty_reg;
    logic [7:0]   sub_reg;
    logic [7:0]   row_reg;
    logic [7:0]   x_reg;
    logic [1:0]   attr_reg;
    logic [7:0]   count_inc;
    logic         frame_ok;
    logic         str_ok;

    assign count_inc = count_reg + 8'd1;
    assign frame_ok  = (pst_reg == P_CSUM) && (xor_reg == in_byte_reg) &&
                       (cmd_reg == CMD_DISPLAYPORT) && (size_reg != 8'd0) && dir_reg;
    assign str_ok    = (size_reg >= STR_MIN_LEN) && (rows_reg != 5'd0) &&
                       (cols_reg != 7'd0) && fc_reg;

    always_comb begin
        status.act = ACT_NONE;
        if (in_op_reg) begin
            status.act = ACT_READ;
        end else if (frame_ok) begin
            case (sub_reg)
                SUB_CLEAR:  status.act = ACT_CLEAR;
                SUB_DRAW:   status.act = wempty_reg ? ACT_NONE : ACT_COPY;
                SUB_STRING: status.act = str_ok ? ACT_STRING : ACT_NONE;
                default:    status.act = ACT_NONE;
            endcase
        end
    end

    // String drawing loop.
    logic [8:0]  i_reg;
    logic [14:0] base_reg;
    logic [7:0]  pay_rd_reg;
    logic [15:0] cell_sum;
    logic        ch_place;
    logic        ch_write;

    assign cell_sum = {1'b0, base_reg} + {8'd0, x_reg};
    assign ch_place = (pay_rd_reg != 8'd0) && (x_reg < 8'(MAX_COLUMNS)) &&
                      (row_reg < 8'(MAX_ROWS));
    assign ch_write = cmd.str_write && ch_place && (cell_sum < 16'(SCREEN_CELLS));
    assign status.str_end = (pay_rd_reg == 8'd0) || ((i_reg + 9'd1) >= {1'b0, size_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pst_reg    <= P_IDLE;
            dir_reg    <= 1'b0;
            size_reg   <= 8'd0;
            count_reg  <= 8'd0;
            cmd_reg    <= 8'd0;
            xor_reg    <= 8'd0;
            wempty_reg <= 1'b1;
        end else if (cmd.exec && !in_op_reg) begin
            case (pst_reg)
                P_HDR: pst_reg <= (in_byte_reg == CH_M) ? P_DIR : P_IDLE;
                P_DIR: begin
                    if (in_byte_reg == CH_LT) begin
                        dir_reg <= 1'b0;
                        pst_reg <= P_SIZE;
                    end else if (in_byte_reg == CH_GT) begin
                        dir_reg <= 1'b1;
                        pst_reg <= P_SIZE;
                    end else begin
                        pst_reg <= P_IDLE;
                    end
                end
                P_SIZE: begin
                    size_reg <= in_byte_reg;
                    xor_reg  <= in_byte_reg;
                    pst_reg  <= P_CMD;
                end
                P_CMD: begin
                    cmd_reg   <= in_byte_reg;
                    xor_reg   <= xor_reg ^ in_byte_reg;
                    count_reg <= 8'd0;
                    pst_reg   <= (size_reg != 8'd0) ? P_DATA : P_CSUM;
                end
                P_DATA: begin
                    count_reg <= count_inc;
                    xor_reg   <= xor_reg ^ in_byte_reg;
                    if (count_inc >= size_reg) pst_reg <= P_CSUM;
                end
                P_CSUM: begin
                    pst_reg <= P_IDLE;
                    if (frame_ok) begin
                        if (sub_reg == SUB_CLEAR || sub_reg == SUB_DRAW) begin
                            wempty_reg <= 1'b1;
                        end else if (sub_reg == SUB_STRING && str_ok) begin
                            wempty_reg <= 1'b0;
                        end
                    end
                end
                default: pst_reg <= (in_byte_reg == CH_DOLLAR) ? P_HDR : P_IDLE;
            endcase
        end
    end

    // Header bytes of the payload kept in registers; the loop advances x.
    always_ff @(posedge aclk) begin
        if (cmd.exec && !in_op_reg && pst_reg == P_DATA) begin
            case (count_reg)
                8'd0:    sub_reg  <= in_byte_reg;
                8'd1:    row_reg  <= in_byte_reg;
                8'd2:    x_reg    <= in_byte_reg;
                8'd3:    attr_reg <= in_byte_reg[1:0];
                default: ;
            endcase
        end else if (cmd.str_write && ch_place) begin
            x_reg <= x_reg + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.str_setup) begin
            base_reg <= 15'(row_reg) * 15'(cols_reg);
            i_reg    <= STR_FIRST_CHAR;
        end else if (cmd.str_write) begin
            i_reg <= i_reg + 9'd1;
        end
    end

    // Payload store.
    logic [7:0] pay_mem [PAYLOAD_DEPTH];

    always_ff @(posedge aclk) begin
        if (cmd.exec && !in_op_reg && pst_reg == P_DATA) begin
            pay_mem[count_reg[PAY_AW-1:0]] <= in_byte_reg;
        end
        if (cmd.str_read) begin
            pay_rd_reg <= pay_mem[i_reg[PAY_AW-1:0]];
        end
    end

    // Screen sweeps.
    logic [AW-1:0] sweep_reg;
    logic          copy_pend_reg;
    logic [AW-1:0] copy_addr_reg;
    logic          sweeping;

    assign sweeping          = cmd.init_sweep || cmd.clear_sweep || cmd.copy_sweep;
    assign status.sweep_last = (sweep_reg == AW'(SCREEN_CELLS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg     <= '0;
            copy_pend_reg <= 1'b0;
        end else begin
            copy_pend_reg <= cmd.copy_sweep;
            if (sweeping) sweep_reg <= status.sweep_last ? '0 : sweep_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        copy_addr_reg <= sweep_reg;
    end

    // Working screen.
    logic [9:0]    wk_mem [SCREEN_CELLS];
    logic [9:0]    wk_rd_reg;
    logic          wk_we;
    logic [AW-1:0] wk_addr;
    logic [9:0]    wk_wdata;

    always_comb begin
        wk_we    = cmd.init_sweep || cmd.clear_sweep || ch_write;
        wk_addr  = sweep_reg;
        wk_wdata = '0;
        if (ch_write) begin
            wk_addr  = cell_sum[AW-1:0];
            wk_wdata = {attr_reg, pay_rd_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (wk_we) wk_mem[wk_addr] <= wk_wdata;
        wk_rd_reg <= wk_mem[sweep_reg];
    end

    // Shown screen.
    logic [9:0]    sh_mem [SCREEN_CELLS];
    logic [9:0]    sh_rd_reg;
    logic          sh_we;
    logic [AW-1:0] sh_addr;
    logic [9:0]    sh_wdata;
    logic          idx_in_range;

    assign sh_we        = cmd.init_sweep || copy_pend_reg;
    assign sh_addr      = copy_pend_reg ? copy_addr_reg : sweep_reg;
    assign sh_wdata     = copy_pend_reg ? wk_rd_reg : 10'd0;
    assign idx_in_range = 13'(in_idx_reg) < 13'(SCREEN_CELLS);

    always_ff @(posedge aclk) begin
        if (sh_we) sh_mem[sh_addr] <= sh_wdata;
        sh_rd_reg <= sh_mem[AW'(in_idx_reg)];
    end

    // Result and output register.
    logic       done_res_reg;
    logic       good_res_reg;
    logic [9:0] cell_res_reg;
    logic       m_valid_reg;
    logic       m_done_reg;
    logic       m_good_reg;
    logic [9:0] m_cell_reg;

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            done_res_reg <= !in_op_reg && (pst_reg == P_CSUM);
            good_res_reg <= !in_op_reg && (pst_reg == P_CSUM) && (xor_reg == in_byte_reg);
            cell_res_reg <= '0;
        end else if (cmd.read_cap) begin
            cell_res_reg <= idx_in_range ? sh_rd_reg : 10'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_done_reg <= done_res_reg;
            m_good_reg <= good_res_reg;
            m_cell_reg <= cell_res_reg;
        end
    end

    assign status.out_free = !m_valid_reg || m_tready;
    assign status.in_valid = s_tvalid;
    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = {6'd0, m_cell_reg};
    assign m_tuser         = {m_good_reg, m_done_reg};

    `AST_IMP(a_wk_addr_range, wk_we, 32'(wk_addr) < SCREEN_CELLS, "working write out of range")
    `AST_IMP(a_good_needs_done, m_valid_reg && m_good_reg, m_done_reg, "good without done")
    `AST_NEXT(a_copy_tail, cmd.copy_sweep && status.sweep_last, copy_pend_reg && !cmd.copy_sweep,
        "copy pipeline tail lost")

endmodule

`default_nettype wire

// ===== hw/rtl/msp_displayport_osd_parser_top.sv =====
// A received byte passes idle, execute and result states; a cell read adds a read state.
// A clear, or a draw of a non-blank working screen, adds a sweep of one screen cell a cycle.
// A string adds a base state, then a read and a write state per payload character.
// One item is in work at a time; the next is taken once the result is in the output register.
// After reset a clearing pass zeroes both screens; no item is taken during it.
// ----------------------------------------------------------------------------
// MSP DisplayPort OSD parser
// Parses MSP v1 frames byte by byte and maintains working and shown OSD screens.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_displayport_osd_parser_top
    import msposd_pkg::*;
#(
    parameter int SCREEN_CELLS = SCREEN_CELLS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // rx_byte [7:0], cell_index [18:8]
    input  wire logic [0:0]  s_tuser,   // op [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // cell_value [9:0]
    output logic [1:0]       m_tuser,   // frame_done [0], frame_good [1]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    msposd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .status   (status),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    msposd_dp #(
        .SCREEN_CELLS (SCREEN_CELLS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

// ===== test/osd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// OSD parser checker
// Watches the byte, result and register channels of the parser, keeps its own
// copy of the frame parser and both screens, and compares every result item
// with the oldest predicted one.
// ----------------------------------------------------------------------------

module osd_checker
    import msposd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // rx_byte [7:0], cell_index [18:8]
    input  wire logic [0:0]  s_tuser,   // op [0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // cell_value [9:0]
    input  wire logic [1:0]  m_tuser,   // frame_done [0], frame_good [1]
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic       done;
        logic       good;
        logic [9:0] cell_val;
    } osd_result_t;

    osd_result_t  expected_q[$];

    logic [6:0]   columns;
    logic [4:0]   rows;
    logic         fc_known;
    parse_state_t pstate;
    logic         from_fc;
    logic [7:0]   pay_size;
    logic [7:0]   pay_count;
    logic [7:0]   command;
    logic [7:0]   csum;
    logic [7:0]   payload [PAYLOAD_DEPTH];
    logic [9:0]   working [SCREEN_CELLS_DEF];
    logic [9:0]   shown [SCREEN_CELLS_DEF];
    logic         working_blank;

    initial fail_count = 0;
    initial pending = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic write_text();
        int         x;
        int         y;
        int         i;
        int         c;
        logic [1:0] attr;
        if (pay_size < STR_MIN_LEN) return;
        if (rows == 0 || columns == 0 || !fc_known) return;
        working_blank = 1'b0;
        y    = payload[1];
        x    = payload[2];
        attr = payload[3][1:0];
        for (i = STR_FIRST_CHAR; i < pay_size; i++) begin
            if (payload[i] == 8'd0) break;
            if (x >= MAX_COLUMNS || y >= MAX_ROWS) continue;
            c = x + y * columns;
            if (c < SCREEN_CELLS_DEF) working[c] = {attr, payload[i]};
            x++;
        end
    endtask

    task automatic run_displayport();
        if (command != CMD_DISPLAYPORT || pay_size == 0 || !from_fc) return;
        case (payload[0])
            SUB_CLEAR: begin
                foreach (working[i]) working[i] = '0;
                working_blank = 1'b1;
            end
            SUB_DRAW: begin
                if (!working_blank) foreach (shown[i]) shown[i] = working[i];
                working_blank = 1'b1;
            end
            SUB_STRING: write_text();
            default: ;
        endcase
    endtask

    task automatic parse_byte(input logic [7:0] b, output osd_result_t r);
        r = '0;
        case (pstate)
            P_HDR: pstate = (b == CH_M) ? P_DIR : P_IDLE;
            P_DIR: begin
                if (b == CH_LT) begin
                    from_fc = 1'b0;
                    pstate  = P_SIZE;
                end else if (b == CH_GT) begin
                    from_fc = 1'b1;
                    pstate  = P_SIZE;
                end else begin
                    pstate = P_IDLE;
                end
            end
            P_SIZE: begin
                pay_size = b;
                csum     = b;
                pstate   = P_CMD;
            end
            P_CMD: begin
                command   = b;
                csum      = csum ^ b;
                pay_count = 8'd0;
                pstate    = (pay_size != 0) ? P_DATA : P_CSUM;
            end
            P_DATA: begin
                payload[pay_count] = b;
                pay_count = pay_count + 8'd1;
                csum      = csum ^ b;
                if (pay_count >= pay_size) pstate = P_CSUM;
            end
            P_CSUM: begin
                r.done = 1'b1;
                if (csum == b) begin
                    r.good = 1'b1;
                    run_displayport();
                end
                pstate = P_IDLE;
            end
            default: pstate = (b == CH_DOLLAR) ? P_HDR : P_IDLE;
        endcase
    endtask

    always @(posedge aclk) begin
        osd_result_t r;
        osd_result_t want;
        if (!aresetn) begin
            columns       = COLUMNS_RST;
            rows          = ROWS_RST;
            fc_known      = FC_TYPE_RST;
            pstate        = P_IDLE;
            from_fc       = 1'b0;
            pay_size      = '0;
            pay_count     = '0;
            command       = '0;
            csum          = '0;
            working_blank = 1'b1;
            foreach (working[i]) working[i] = '0;
            foreach (shown[i]) shown[i] = '0;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $display("MISMATCH unexpected result item at %0t", $realtime);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_tuser[0] !== want.done)
                        report_mismatch("frame_done", m_tuser[0], want.done);
                    if (m_tuser[1] !== want.good)
                        report_mismatch("frame_good", m_tuser[1], want.good);
                    if (m_tdata !== {6'd0, want.cell_val})
                        report_mismatch("cell_value", m_tdata, want.cell_val);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_COLUMNS: columns = cfg_data;
                    CFG_ROWS:    rows = cfg_data[4:0];
                    CFG_FC_TYPE: fc_known = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0]) begin
                    r = '0;
                    if (s_tdata[18:8] < SCREEN_CELLS_DEF) r.cell_val = shown[s_tdata[18:8]];
                end else begin
                    parse_byte(s_tdata[7:0], r);
                end
                expected_q.push_back(r);
            end
        end
        pending <= expected_q.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// OSD parser testbench
// Sends MSP frames, noise and screen reads to the parser under random gaps and
// output stalls, across several register settings, and reports the verdict of
// the checker.
// ----------------------------------------------------------------------------

module testbench;
    import msposd_pkg::*;

    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam logic       OP_BYTE     = 1'b0;
    localparam logic       OP_READ     = 1'b1;
    localparam logic [7:0] CMD_OTHER   = 8'd100;
    localparam logic [7:0] SUB_KEEP    = 8'd0;
    localparam logic [7:0] SUB_BOGUS   = 8'd7;
    localparam int         CYCLE_CAP   = 4000000;
    localparam int         ITEM_TARGET = 290;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data  = '0;
    int          fail_count;
    int          pending;
    int          cycles    = 0;
    int          sent      = 0;
    int          stall_left = 0;
    logic [7:0]  pl[$];

    msp_displayport_osd_parser_top u_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    osd_checker u_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .fail_count, .pending
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Output back-pressure: random runs of ready and stall.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_tready   <= 1'b1;
            stall_left <= $urandom_range(0, 30);
        end
    end

    task automatic push_item(input logic op, input logic [7:0] b, input logic [10:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, idx, b};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        sent++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(OP_BYTE, b, 11'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input int idx);
        push_item(OP_READ, 8'($urandom_range(0, 255)), 11'(idx));
    endtask

    task automatic send_frame(input logic [7:0] dir, input logic [7:0] cmd,
                              input logic [7:0] body[$], input bit corrupt);
        logic [7:0] x;
        x = 8'(body.size()) ^ cmd;
        push_byte(CH_DOLLAR);
        push_byte(CH_M);
        push_byte(dir);
        push_byte(8'(body.size()));
        push_byte(cmd);
        foreach (body[i]) begin
            push_byte(body[i]);
            x = x ^ body[i];
        end
        push_byte(corrupt ? x ^ 8'(1 << $urandom_range(0, 7)) : x);
    endtask

    task automatic display_cmd(input logic [7:0] sub);
        logic [7:0] body[$];
        body = '{sub};
        send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'b0);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_screen(input logic [6:0] c, input logic [4:0] r, input logic f);
        wait_idle();
        write_reg(CFG_COLUMNS, c);
        write_reg(CFG_ROWS, 7'(r));
        write_reg(CFG_FC_TYPE, 7'(f));
    endtask

    task automatic random_text(output logic [7:0] body[$]);
        int n;
        body = '{SUB_STRING, 8'($urandom_range(0, 25)), 8'($urandom_range(0, 66)),
                 8'($urandom_range(0, 255))};
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
        repeat (n) body.push_back(($urandom_range(0, 15) == 0) ? 8'd0
                                  : 8'($urandom_range(1, 255)));
    endtask

    initial begin
        logic [7:0] body[$];
        int         r;
        int         phase;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reads at both ends of the screen and beyond it.
        read_cell(0);
        read_cell(SCREEN_CELLS_DEF - 1);
        read_cell(SCREEN_CELLS_DEF);
        read_cell(2047);
        display_cmd(SUB_CLEAR);
        body = '{SUB_STRING, 8'd0, 8'd0, 8'd3, "A", "B"};
        send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'b0);
        display_cmd(SUB_DRAW);
        read_cell(0);
        read_cell(1);
        // Text stops at a zero byte and runs on into the next row.
        body = '{SUB_STRING, 8'd1, 8'd28, 8'hFF, "x", "y", "w", 8'd0, "z"};
        send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'b0);
        // Column and row limits.
        body = '{SUB_STRING, 8'd0, 8'd63, 8'd1, "p", "q", "r"};
        send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'b0);
        body = '{SUB_STRING, 8'd24, 8'd0, 8'd2, "s"};
        send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'b0);
        display_cmd(SUB_DRAW);
        for (int i = 58; i < 64; i++) read_cell(i);
        // Frames with no screen effect, and broken ones.
        display_cmd(SUB_DRAW);
        body = '{};
        send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'b0);
        body = '{SUB_STRING, 8'd2, 8'd0, 8'd0, "t"};
        send_frame(CH_LT, CMD_DISPLAYPORT, body, 1'b0);
        send_frame(CH_GT, CMD_OTHER, body, 1'b0);
        send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'b1);
        body = '{SUB_STRING, 8'd2, 8'd0, 8'd0};
        send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'b0);
        display_cmd(SUB_KEEP);
        display_cmd(SUB_BOGUS);
        push_byte(CH_DOLLAR);
        push_byte(CH_DOLLAR);
        push_byte(CH_DOLLAR);
        push_byte(CH_M);
        push_byte("Z");
        display_cmd(SUB_DRAW);
        read_cell(60);

        // Strings disabled by each register, then an oversized stride.
        body = '{SUB_STRING, 8'd3, 8'd3, 8'd1, "d"};
        set_screen(7'd0, 5'd16, 1'b1);
        send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'b0);
        set_screen(7'd30, 5'd0, 1'b1);
        send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'b0);
        set_screen(7'd30, 5'd16, 1'b0);
        send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'b0);
        display_cmd(SUB_DRAW);
        set_screen(7'd127, 5'd31, 1'b1);
        write_reg(CFG_UNUSED, 7'h7F);
        body = '{SUB_STRING, 8'd23, 8'd0, 8'd2, "e", "f"};
        send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'b0);
        body = '{SUB_STRING, 8'd12, 8'd0, 8'd1, "g", "h"};
        send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'b0);
        display_cmd(SUB_DRAW);
        read_cell(1524);
        read_cell(1525);
        set_screen(7'd64, 5'd24, 1'b1);
        body = '{SUB_STRING, 8'd0, 8'd40, 8'd0};
        repeat (30) body.push_back(8'($urandom_range(1, 255)));
        send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'b0);
        display_cmd(SUB_DRAW);
        read_cell(63);

        phase = 0;
        do begin
            case (phase % 5)
                0: set_screen(7'd30, 5'd16, 1'b1);
                1: set_screen(7'd64, 5'd24, 1'b1);
                2: set_screen(7'd16, 5'd8, 1'b1);
                3: set_screen(7'd127, 5'd31, 1'b1);
                default: set_screen(7'($urandom_range(1, 127)), 5'($urandom_range(1, 31)),
                                    1'($urandom_range(0, 1)));
            endcase
            phase++;
            repeat (8) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    random_text(body);
                    send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'b0);
                end else if (r < 55) begin
                    display_cmd(SUB_DRAW);
                end else if (r < 58) begin
                    display_cmd(SUB_CLEAR);
                end else if (r < 72) begin
                    repeat ($urandom_range(1, 4)) read_cell($urandom_range(0, 2047));
                end else if (r < 80) begin
                    repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
                end else if (r < 88) begin
                    random_text(body);
                    send_frame(($urandom_range(0, 1) != 0) ? CH_LT : CH_GT,
                               ($urandom_range(0, 1) != 0) ? CMD_OTHER : CMD_DISPLAYPORT,
                               body, 1'($urandom_range(0, 1)));
                end else if (r < 94) begin
                    body = '{};
                    repeat ($urandom_range(0, 6)) body.push_back(8'($urandom_range(0, 255)));
                    send_frame(CH_GT, CMD_DISPLAYPORT, body, 1'($urandom_range(0, 1)));
                end else begin
                    push_byte(CH_DOLLAR);
                    if ($urandom_range(0, 1) != 0) push_byte(8'($urandom_range(0, 255)));
                    else begin
                        push_byte(CH_M);
                        push_byte(8'($urandom_range(0, 255)));
                    end
                end
            end
        end while (sent < ITEM_TARGET);

        wait_idle();
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/msposd_pkg.sv
hw/rtl/msposd_ctrl.sv
hw/rtl/msposd_dp.sv
hw/rtl/msp_displayport_osd_parser_top.sv
test/osd_checker.sv
test/testbench.sv
